// ===== hdl/parity_replacement_cache_assert.svh =====
// Assertion macros for the checker of the parity replacement cache.
// No dependencies; included by hdl/prc_checker.sv.
`ifndef PARITY_REPLACEMENT_CACHE_ASSERT_SVH
`define PARITY_REPLACEMENT_CACHE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PRC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/prc_pkg.sv =====
// Types and constants of the parity replacement cache.
// No dependencies; used by hdl/parity_replacement_cache.sv and hdl/prc_checker.sv.
package prc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned S_TUSER_W   = 2;
  localparam int unsigned M_TDATA_W   = 104;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_PUT   = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_EVICT,
    ST_SHIFT,
    ST_LAST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] addr;
    logic [VAL_W-1:0] data;
    logic             clean;
  } entry_t;

  // hit sits in bit 0
  typedef struct packed {
    logic             evicted_clean;
    logic [VAL_W-1:0] evicted_data;
    logic [KEY_W-1:0] evicted_addr;
    logic             evicted;
    logic [VAL_W-1:0] read_data;
    logic             hit;
  } result_t;

  localparam int unsigned ENTRY_W  = $bits(entry_t);
  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ===== hdl/prc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/parity_replacement_cache.sv =====
// Parity replacement cache: fully associative table in insertion order.
// Depends on prc_pkg and prc_ram.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: action; tdata: addr, data_in
//  m_axis    out  m_axis_tvalid/tready       tdata: hit .. evicted_clean
//
// One item at a time, all table entries in one RAM with one read and one write port.
// Read/write scan one slot a cycle; a put goes straight to insertion, no scan.
// Insertion into a full table: an odd address replaces the last slot; an even
// address evicts slot 0 and shifts the rest down; a write miss scans first.
// Reset empties the table at once (fill count only); a stalled result holds in
// the output register while the next word is already accepted and worked on.
module parity_replacement_cache #(
  parameter int unsigned ENTRIES = prc_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] addr, [63:32] data_in
  input  logic [prc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [prc_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] hit, [32:1] read_data, [33] evicted, [65:34] evicted_addr,
  // [97:66] evicted_data, [98] evicted_clean, [103:99] zero
  output logic [prc_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  import prc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [IW-1:0] SHIFT_END = IW'(ENTRIES - 2);

  state_e           state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [IW-1:0]    idx_q, idx_d;
  action_e          act_q, act_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  result_t          res_q, res_d;
  result_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  logic    in_fire, out_free, match, last_scan, full;
  action_e in_act;
  entry_t  new_entry;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_act    = action_e'(s_axis_tuser_i);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign match     = ram_rdata.addr == key_q;
  assign last_scan = (CW'(idx_q) + CW'(1)) == fill_q;
  assign full      = fill_q == CW'(ENTRIES);
  assign new_entry = '{addr: key_q, data: val_q, clean: act_q == ACT_PUT};

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - RESULT_W)'(0), out_q};

  prc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_prc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_act)
            ACT_READ:  state_d = (fill_q == '0) ? ST_DONE : ST_SCAN;
            ACT_WRITE: state_d = (fill_q == '0) ? ST_INSERT : ST_SCAN;
            ACT_PUT:   state_d = ST_INSERT;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_DONE;
        end else if (last_scan) begin
          state_d = (act_q == ACT_READ) ? ST_DONE : ST_INSERT;
        end
      end
      ST_INSERT: state_d = full ? ST_EVICT : ST_DONE;
      ST_EVICT:  state_d = key_q[0] ? ST_LAST : ST_SHIFT;
      ST_SHIFT:  state_d = (idx_q == SHIFT_END) ? ST_LAST : ST_SHIFT;
      ST_LAST:   state_d = ST_DONE;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    ram_raddr = idx_q + IW'(1);
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_entry;
    case (state_q)
      ST_IDLE: ram_raddr = '0;
      ST_SCAN: begin
        if (match && act_q == ACT_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = '{addr: key_q, data: val_q, clean: 1'b0};
        end
      end
      ST_INSERT: begin
        ram_raddr = key_q[0] ? LAST_IDX : '0;
        if (!full) begin
          ram_we    = 1'b1;
          ram_waddr = fill_q[IW-1:0];
        end
      end
      ST_EVICT: ram_raddr = IW'(1);
      ST_SHIFT: begin
        ram_raddr = idx_q + IW'(2);
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = LAST_IDX;
      end
      default: ram_raddr = '0;
    endcase
  end

  // datapath
  always_comb begin
    fill_d      = fill_q;
    idx_d       = idx_q;
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_d = in_act;
          key_d = s_axis_tdata_i[KEY_W-1:0];
          val_d = s_axis_tdata_i[KEY_W +: VAL_W];
          idx_d = '0;
          res_d = '0;
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_d.hit = 1'b1;
          if (act_q == ACT_READ) begin
            res_d.read_data = ram_rdata.data;
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_INSERT: begin
        if (!full) begin
          fill_d = fill_q + CW'(1);
        end
      end
      ST_EVICT: begin
        res_d.evicted       = 1'b1;
        res_d.evicted_addr  = ram_rdata.addr;
        res_d.evicted_data  = ram_rdata.data;
        res_d.evicted_clean = ram_rdata.clean;
        idx_d               = '0;
      end
      ST_SHIFT: idx_d = idx_q + IW'(1);
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    act_q <= act_d;
    key_q <= key_d;
    val_q <= val_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

// ===== hdl/prc_checker.sv =====
// Port-level checker of the parity replacement cache, bound to the top level.
// Depends on prc_pkg and parity_replacement_cache_assert.svh.
`include "parity_replacement_cache_assert.svh"

module prc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [prc_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import prc_pkg::*;

  `PRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result word changed")
  `PRC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "word accepted while busy")
  `PRC_ASSERT_IMP(a_hit_xor_evict, clk_i, rst_ni, m_axis_tvalid_o, !(m_axis_tdata_o[0] && m_axis_tdata_o[33]), "hit and eviction in one result")
  `PRC_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[0], m_axis_tdata_o[32:1] == '0, "read data without hit")
  `PRC_ASSERT_IMP(a_no_evict_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[33], m_axis_tdata_o[103:34] == '0, "eviction fields without eviction")

endmodule

bind parity_replacement_cache prc_checker u_prc_checker (.*);
